[src/kcl_pkg.sv]
// Shared types, codes and reset values for the keypad code lock.
package kcl_pkg;

  localparam int KEY_W    = 4;
  localparam int CODE_W   = 16;
  localparam int STATUS_W = 4;
  localparam int SLOTS    = 4;
  localparam int SLOT_W   = 2;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [STATUS_W-1:0] status_t;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_ENTRY = 3'd1,
    MODE_SLOT  = 3'd2,
    MODE_AUTH  = 3'd3,
    MODE_NEW   = 3'd4
  } mode_t;

  localparam key_t KEY_STAR = 4'd14;
  localparam key_t KEY_HASH = 4'd15;

  localparam logic [1:0] LOCK_LEVEL = 2'd3;

  localparam status_t ST_MASTER   = 4'd0;
  localparam status_t ST_SLOT1    = 4'd1;
  localparam status_t ST_CHG_GO   = 4'd5;
  localparam status_t ST_FAIL3    = 4'd6;
  localparam status_t ST_CHG_OK   = 4'd7;
  localparam status_t ST_FAIL1    = 4'd8;
  localparam status_t ST_FAIL2    = 4'd9;
  localparam status_t ST_UNLOCK   = 4'd10;
  localparam status_t ST_PROG1    = 4'd11;
  localparam status_t ST_REJECT   = 4'd14;
  localparam status_t ST_SAVED    = 4'd15;

  localparam code_t MASTER_RESET = 16'h01AC;
  localparam code_t USER_RESET [SLOTS] = '{16'h4321, 16'h8765, 16'h0000, 16'h1111};

endpackage

[src/keypad_code_lock.sv]
// Keypad code lock: code entry, lockout and code change in a single pass per key.
// A key's status beat, if it has one, is loaded into the output register as the key is accepted.
// Throughput: one key per cycle; the input stalls only while a status beat waits.
// The whole key decision is one combinational pass into the state and output registers.
// Reset (rst_n low, synchronous) returns to idle, clears the failure count and loads
// the default master code and the four default user codes.
module keypad_code_lock
  import kcl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cfg_we,
  input  code_t   cfg_wdata,
  input  logic    in_valid,
  output logic    in_stall,
  input  key_t    in_key,
  output logic    out_valid,
  input  logic    out_stall,
  output status_t out_status_code
);

  // State registers.
  mode_t       mode_r,    mode_nxt;
  logic [1:0]  pos_r,     pos_nxt;
  code_t       entered_r, entered_nxt;
  key_t        slot_r,    slot_nxt;
  logic [1:0]  fails_r,   fails_nxt;
  code_t       master_r;
  code_t       user_r [SLOTS];

  // Output register.
  logic    out_valid_r,  out_valid_nxt;
  status_t out_status_r, out_status_nxt;

  logic    in_accept;
  logic    res_vld;
  status_t res_code;
  logic    user_we;
  code_t   code_ins;
  logic    last_key;
  logic [SLOTS-1:0] user_hit;
  logic    master_hit;
  logic [SLOT_W-1:0] wr_slot;

  // A new key is taken unless a finished status beat is still waiting downstream.
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign out_valid       = out_valid_r;
  assign out_status_code = out_status_r;

  // The incoming key lands in the nibble of the current position; the compares
  // below look at the code with this key already in place.
  always_comb begin
    code_ins = entered_r;
    code_ins[{pos_r, 2'b00} +: KEY_W] = in_key;
  end

  assign last_key = (pos_r == 2'd3);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      user_hit[i] = (code_ins == user_r[i]);
    end
  end
  assign master_hit = (code_ins == master_r);

  // Slot keys 1-4 map to entries 0-3.
  assign wr_slot = slot_r[SLOT_W-1:0] - 2'd1;

  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    entered_nxt = entered_r;
    slot_nxt    = slot_r;
    fails_nxt   = fails_r;
    res_vld     = 1'b0;
    res_code    = ST_MASTER;
    user_we     = 1'b0;

    if (in_accept) begin
      unique case (mode_r)
        MODE_ENTRY, MODE_AUTH, MODE_NEW: begin
          // Every key value is a code key during a four-key entry.
          entered_nxt = code_ins;
          pos_nxt     = last_key ? 2'd0 : pos_r + 2'd1;
          if (!last_key) begin
            res_vld  = 1'b1;
            res_code = ST_PROG1 + {2'b00, pos_r};
          end else if (mode_r == MODE_ENTRY) begin
            mode_nxt = MODE_IDLE;
            if (fails_r == LOCK_LEVEL) begin
              // Locked: only the master code clears it, and a miss stays silent.
              if (master_hit) begin
                fails_nxt = 2'd0;
                res_vld   = 1'b1;
                res_code  = ST_UNLOCK;
              end
            end else if (user_hit[0]) begin
              fails_nxt = 2'd0;
              res_vld   = 1'b1;
              res_code  = ST_SLOT1;
            end else if (user_hit[1]) begin
              fails_nxt = 2'd0;
              res_vld   = 1'b1;
              res_code  = ST_SLOT1 + 4'd1;
            end else if (user_hit[2]) begin
              fails_nxt = 2'd0;
              res_vld   = 1'b1;
              res_code  = ST_SLOT1 + 4'd2;
            end else if (user_hit[3]) begin
              fails_nxt = 2'd0;
              res_vld   = 1'b1;
              res_code  = ST_SLOT1 + 4'd3;
            end else if (master_hit) begin
              fails_nxt = 2'd0;
              res_vld   = 1'b1;
              res_code  = ST_MASTER;
            end else begin
              fails_nxt = fails_r + 2'd1;
              res_vld   = 1'b1;
              case (fails_r)
                2'd0:    res_code = ST_FAIL1;
                2'd1:    res_code = ST_FAIL2;
                default: res_code = ST_FAIL3;
              endcase
            end
          end else if (mode_r == MODE_AUTH) begin
            // The change goes ahead only for slots 1-4 and the right master code.
            res_vld = 1'b1;
            if ((slot_r >= 4'd1) && (slot_r <= 4'd4) && master_hit) begin
              mode_nxt = MODE_NEW;
              res_code = ST_CHG_OK;
            end else begin
              mode_nxt = MODE_IDLE;
              res_code = ST_REJECT;
            end
          end else begin
            user_we  = 1'b1;
            mode_nxt = MODE_IDLE;
            res_vld  = 1'b1;
            res_code = ST_SAVED;
          end
        end
        MODE_SLOT: begin
          // Any key is taken as the slot key, silently.
          slot_nxt = in_key;
          pos_nxt  = 2'd0;
          mode_nxt = MODE_AUTH;
        end
        default: begin
          // Idle, and the unused mode codes behave the same way.
          mode_nxt = MODE_IDLE;
          if (in_key == KEY_HASH) begin
            mode_nxt = MODE_ENTRY;
            pos_nxt  = 2'd0;
          end else if ((in_key == KEY_STAR) && (fails_r != LOCK_LEVEL)) begin
            mode_nxt = MODE_SLOT;
            res_vld  = 1'b1;
            res_code = ST_CHG_GO;
          end
        end
      endcase
    end
  end

  // The status register loads with each key beat and otherwise drains when taken.
  always_comb begin
    out_status_nxt = out_status_r;
    if (in_accept) begin
      out_valid_nxt  = res_vld;
      out_status_nxt = res_code;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      pos_r       <= 2'd0;
      entered_r   <= '0;
      slot_r      <= '0;
      fails_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      entered_r   <= entered_nxt;
      slot_r      <= slot_nxt;
      fails_r     <= fails_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
  end

  // Master code register, written from the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= MASTER_RESET;
    end else if (cfg_we) begin
      master_r <= cfg_wdata;
    end
  end

  // User code slots; the new code is the one with the last key in place.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        user_r[i] <= USER_RESET[i];
      end
    end else if (user_we) begin
      user_r[wr_slot] <= code_ins;
    end
  end

`ifndef SYNTHESIS
  // While locked, a star key in idle must not start a code change.
  a_lock_blocks_change: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (mode_r == MODE_IDLE) && (fails_r == LOCK_LEVEL) && (in_key == KEY_STAR)
    |=> !out_valid_r && (mode_r == MODE_IDLE))
    else $error("star key started a change while locked");

  // The fourth new key saves the code, reports it and returns to idle.
  a_save_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (mode_r == MODE_NEW) && (pos_r == 2'd3)
    |=> out_valid_r && (out_status_r == ST_SAVED) && (mode_r == MODE_IDLE))
    else $error("code save did not complete as expected");

  // The failure count moves only on an accepted key beat.
  a_fails_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_accept) |-> $stable(fails_r))
    else $error("failure count changed without a key beat");
`endif

endmodule

[tb/keypad_code_lock_tb.sv]
// Self-checking testbench for the keypad code lock: directed script plus random key sequences.
`timescale 1ns / 1ps

module keypad_code_lock_tb
  import kcl_pkg::*;
();

  // Cycle budget for the whole run.
  localparam int LIMIT_CYCLES = 200000;
  localparam int SCRIPT_ROWS  = 27;

  // How a scripted key beat is checked: against the predictor, as a beat that must
  // produce no status, or against a status typed into the script.
  typedef enum logic [1:0] {
    BY_MODEL,
    NO_STATUS,
    FIXED_STATUS
  } row_check_t;

  typedef struct packed {
    key_t       key;
    row_check_t check;
    status_t    status;
  } key_row_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    cfg_we    = 1'b0;
  code_t   cfg_wdata = '0;
  logic    in_valid  = 1'b0;
  key_t    in_key    = '0;
  logic    out_stall = 1'b0;
  logic    in_stall;
  logic    out_valid;
  status_t out_status_code;

  // While set, neither side inserts idle cycles.
  bit no_gaps = 1'b0;

  int      mismatches  = 0;
  int      keys_sent   = 0;
  int      cycle_count = 0;
  status_t status_due [$];
  status_t status_want;

  // Predictor copy of the lock state and of the master code register.
  mode_t      lock_mode  = MODE_IDLE;
  logic [1:0] key_pos    = '0;
  code_t      typed_code = '0;
  key_t       slot_pick  = '0;
  logic [1:0] fail_count = '0;
  code_t      slot_code [SLOTS] = USER_RESET;
  code_t      master_now = MASTER_RESET;

  // Directed script, run from reset with the default master code (keys C, A, 1, 0).
  // It opens slot 1, re-codes slot 2 with star and hash inside the new code, opens
  // slot 2 with that code, and then asks for a change with a slot key out of range.
  key_row_t script [SCRIPT_ROWS] = '{
    '{4'd9,     NO_STATUS,    ST_MASTER},   // plain digit in idle is ignored
    '{KEY_HASH, NO_STATUS,    ST_MASTER},
    '{4'd1,     BY_MODEL,     ST_MASTER},
    '{4'd2,     BY_MODEL,     ST_MASTER},
    '{4'd3,     BY_MODEL,     ST_MASTER},
    '{4'd4,     FIXED_STATUS, ST_SLOT1},    // default slot 1 code
    '{KEY_STAR, FIXED_STATUS, ST_CHG_GO},
    '{4'd2,     NO_STATUS,    ST_MASTER},   // slot key
    '{4'd12,    BY_MODEL,     ST_MASTER},
    '{4'd10,    BY_MODEL,     ST_MASTER},
    '{4'd1,     BY_MODEL,     ST_MASTER},
    '{4'd0,     FIXED_STATUS, ST_CHG_OK},
    '{KEY_HASH, BY_MODEL,     ST_MASTER},   // hash and star are plain code keys here
    '{KEY_STAR, BY_MODEL,     ST_MASTER},
    '{4'd0,     BY_MODEL,     ST_MASTER},
    '{4'd15,    FIXED_STATUS, ST_SAVED},
    '{KEY_HASH, NO_STATUS,    ST_MASTER},
    '{KEY_HASH, BY_MODEL,     ST_MASTER},
    '{KEY_STAR, BY_MODEL,     ST_MASTER},
    '{4'd0,     BY_MODEL,     ST_MASTER},
    '{KEY_HASH, BY_MODEL,     ST_MASTER},   // new slot 2 code opens the lock
    '{KEY_STAR, FIXED_STATUS, ST_CHG_GO},
    '{4'd0,     NO_STATUS,    ST_MASTER},   // slot key 0 names no slot
    '{4'd12,    BY_MODEL,     ST_MASTER},
    '{4'd10,    BY_MODEL,     ST_MASTER},
    '{4'd1,     BY_MODEL,     ST_MASTER},
    '{4'd0,     FIXED_STATUS, ST_REJECT}    // right master code, but no valid slot
  };

  keypad_code_lock i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status_code (out_status_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the status that one accepted key beat causes and advances the
  // predictor state. has is cleared when the key causes no status beat.
  function automatic void next_status(input key_t k, output bit has, output status_t st);
    logic [1:0] pos;
    logic [1:0] idx;
    bit         hit;
    int         i;
    has = 1'b0;
    st  = ST_MASTER;
    hit = 1'b0;
    case (lock_mode)
      MODE_ENTRY, MODE_AUTH, MODE_NEW: begin
        // Every four-key entry fills the code buffer first key lowest.
        pos = key_pos;
        typed_code[4*pos +: 4] = k;
        key_pos = pos + 2'd1;
        if (pos != 2'd3) begin
          has = 1'b1;
          st  = ST_PROG1 + status_t'(pos);
        end else if (lock_mode == MODE_ENTRY) begin
          lock_mode = MODE_IDLE;
          if (fail_count == LOCK_LEVEL) begin
            // Locked: only the master code counts, and a wrong code stays silent.
            if (typed_code == master_now) begin
              fail_count = '0;
              has = 1'b1;
              st  = ST_UNLOCK;
            end
          end else begin
            has = 1'b1;
            // The lowest matching slot wins; the master code is tried last.
            for (i = 0; i < SLOTS; i++) begin
              if (!hit && typed_code == slot_code[i]) begin
                hit = 1'b1;
                st  = ST_SLOT1 + status_t'(i);
              end
            end
            if (!hit && typed_code == master_now) begin
              hit = 1'b1;
              st  = ST_MASTER;
            end
            if (hit) begin
              fail_count = '0;
            end else begin
              fail_count = fail_count + 2'd1;
              case (fail_count)
                2'd1:    st = ST_FAIL1;
                2'd2:    st = ST_FAIL2;
                default: st = ST_FAIL3;
              endcase
            end
          end
        end else if (lock_mode == MODE_AUTH) begin
          has = 1'b1;
          if (slot_pick >= 4'd1 && slot_pick <= 4'd4 && typed_code == master_now) begin
            lock_mode = MODE_NEW;
            st = ST_CHG_OK;
          end else begin
            lock_mode = MODE_IDLE;
            st = ST_REJECT;
          end
        end else begin
          idx = 2'(slot_pick - 4'd1);
          slot_code[idx] = typed_code;
          lock_mode = MODE_IDLE;
          has = 1'b1;
          st  = ST_SAVED;
        end
      end
      MODE_SLOT: begin
        // Any key is taken as the slot key, silently.
        slot_pick = k;
        key_pos   = '0;
        lock_mode = MODE_AUTH;
      end
      default: begin
        lock_mode = MODE_IDLE;
        if (k == KEY_HASH) begin
          lock_mode = MODE_ENTRY;
          key_pos   = '0;
        end else if (k == KEY_STAR && fail_count < LOCK_LEVEL) begin
          lock_mode = MODE_SLOT;
          has = 1'b1;
          st  = ST_CHG_GO;
        end
      end
    endcase
  endfunction

  // Presents one key beat, with random idle cycles in front of it, and holds it
  // until the lock takes it. At the accepting edge the predictor runs and the
  // status that the beat should cause is queued.
  task automatic send_key(input key_t k, input row_check_t check = BY_MODEL,
                          input status_t fixed = ST_MASTER);
    bit      has;
    status_t st;
    while (!no_gaps && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key   <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    keys_sent++;
    next_status(k, has, st);
    case (check)
      BY_MODEL:     if (has) status_due.push_back(st);
      FIXED_STATUS: status_due.push_back(fixed);
      default:      ;
    endcase
  endtask

  // Sends the four keys of a code, first key from the low nibble.
  task automatic send_code(input code_t c);
    int n;
    for (n = 0; n < 4; n++) send_key(c[4*n +: 4]);
  endtask

  // Drops valid and waits until every queued status beat has come back. The short
  // extra wait covers a key beat that causes no status and may still be in flight.
  task automatic drain_status();
    in_valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Random traffic. Most of it is well-formed: entries of known codes, which mostly
  // reset the failure count or unlock, guessed codes, which mostly fail and drive the
  // lock into lockout, and complete code changes. The rest is loose keys and
  // sequences broken off part way.
  task automatic random_keys(input int n);
    int    stop_at;
    int    pick;
    int    i;
    int    len;
    code_t c;
    stop_at = keys_sent + n;
    while (keys_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        i = $urandom_range(SLOTS);
        c = (i == SLOTS) ? master_now : slot_code[i];
        send_key(KEY_HASH);
        send_code(c);
      end else if (pick < 60) begin
        send_key(KEY_HASH);
        send_code(code_t'($urandom));
      end else if (pick < 78) begin
        send_key(KEY_STAR);
        send_key(($urandom_range(9) < 8) ? key_t'($urandom_range(4, 1))
                                         : key_t'($urandom_range(15)));
        send_code(($urandom_range(9) < 8) ? master_now : code_t'($urandom));
        case ($urandom_range(9))
          0:       c = '0;
          1:       c = '1;
          default: c = code_t'($urandom);
        endcase
        send_code(c);
      end else if (pick < 90) begin
        len = $urandom_range(3, 1);
        for (i = 0; i < len; i++) send_key(key_t'($urandom_range(15)));
      end else if (pick < 97) begin
        // Start an entry or a change and break off; later keys land mid-sequence.
        send_key($urandom_range(1) ? KEY_HASH : KEY_STAR);
        len = $urandom_range(3, 1);
        for (i = 0; i < len; i++) send_key(key_t'($urandom_range(15)));
      end else begin
        // The sender holds off until the lock has answered everything so far.
        drain_status();
      end
    end
  endtask

  // One phase: settle the lock, write a new master code and run random traffic.
  task automatic run_phase(input code_t master, input bit steady, input int n);
    drain_status();
    cfg_we    <= 1'b1;
    cfg_wdata <= master;
    @(posedge clk);
    cfg_we <= 1'b0;
    master_now = master;
    no_gaps = steady;
    random_keys(n);
    no_gaps = 1'b0;
  endtask

  // The status side stalls at random, except while no_gaps is set.
  always @(posedge clk) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 25);
  end

  // Every status beat taken is compared with the oldest pending status.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        $display("%0t: status beat with none pending: expected nothing, got %0d",
                 $time, out_status_code);
        mismatches++;
      end else begin
        status_want = status_due.pop_front();
        if (out_status_code !== status_want) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, status_want, out_status_code);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[r]) send_key(script[r].key, script[r].check, script[r].status);

    // Master code settings: all zeros, which equals the default slot 3 code so the
    // slot must win; all ones; a copy of a live user code; and random values, one
    // of them over a long stretch with no idle cycles on either side.
    run_phase('0, 1'b0, 280);
    run_phase('1, 1'b0, 280);
    run_phase(slot_code[$urandom_range(SLOTS - 1)], 1'b0, 280);
    run_phase(code_t'($urandom), 1'b1, 300);
    run_phase(code_t'($urandom), 1'b0, 280);

    drain_status();
    repeat (5) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
